// File: design/cdct_pkg.sv
// ----------------------------------------------------------------------------
// Conditional delay command table: shared definitions
// Table depth, field widths, operation and result codes, and the entry and
// cell control types used between the table cells and the top level.
// ----------------------------------------------------------------------------
package cdct_pkg;

	// Table size and derived index widths.
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// Field widths.
	localparam int OP_W = 3;
	localparam int DELAY_W = 16;
	localparam int TAG_W = 16;
	localparam int COND_W = 4;

	// Operation codes carried in the input tuser.
	localparam logic [OP_W-1:0] OP_ADD = 3'd0;
	localparam logic [OP_W-1:0] OP_TICK = 3'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
	localparam logic [OP_W-1:0] OP_PAUSE = 3'd3;
	localparam logic [OP_W-1:0] OP_RESUME = 3'd4;

	// Result kinds carried in the output tuser.
	localparam logic KIND_FIRED = 1'b0;
	localparam logic KIND_REJECT = 1'b1;

	// An entry fires once its delay, after the decrement, is zero or less.
	localparam logic signed [DELAY_W-1:0] DELAY_FIRE_MAX = 16'sd1;
	localparam logic signed [DELAY_W-1:0] DELAY_STEP = 16'sd1;

	// One table entry.
	typedef struct packed {
		logic signed [DELAY_W-1:0] delay;
		logic [COND_W-1:0]         mask;
		logic [TAG_W-1:0]          tag;
	} entry_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic wr;    // load the appended entry
		logic shift; // take the entry of the cell above
		logic upd;   // selected entry stays: apply the tick to it
	} cell_ctrl_t;

endpackage

// File: design/cdct_cell.sv
// ----------------------------------------------------------------------------
// Conditional delay command table: table cell
// Holds one entry, evaluates it against the current conditions and either
// loads a new entry, takes its upper neighbor's entry or ages its own delay.
// ----------------------------------------------------------------------------
module cdct_cell (
	input  logic                              clk,
	input  cdct_pkg::cell_ctrl_t              ctrl,
	input  logic [cdct_pkg::COND_W-1:0]       cond,
	input  cdct_pkg::entry_t                  add_entry,
	input  cdct_pkg::entry_t                  above,
	output cdct_pkg::entry_t                  entry,
	output logic                              fire
);

	cdct_pkg::entry_t entry_q;
	logic             active;

	// The entry is active when every required condition bit is set.
	assign active = ((entry_q.mask & cond) == entry_q.mask);
	assign fire = active && ($signed(entry_q.delay) <= cdct_pkg::DELAY_FIRE_MAX);
	assign entry = entry_q;

	// Entry storage: append, close a gap above, or count down.
	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			entry_q <= add_entry;
		end else if (ctrl.shift) begin
			entry_q <= above;
		end else if (ctrl.upd && active) begin
			entry_q.delay <= entry_q.delay - cdct_pkg::DELAY_STEP;
		end
	end

endmodule

// File: design/conditional_delay_command_table.sv
// ----------------------------------------------------------------------------
// Conditional delay command table
// Ordered table of pending commands, aged by ticks and fired when due.
// ----------------------------------------------------------------------------
// Add, clear, pause and resume are done as they are accepted, but for an add to
// a full table. A tick that starts a walk keeps the input closed while a single
// select pointer walks the row of cells from the highest entry down, one cell
// per cycle unless a firing entry finds the output register held by m_tready,
// and a fired entry is removed in the same cycle by shifting the cells above it
// down by one. An add to a full table keeps the input closed until the output
// register is free, and its reject beat is loaded as the input opens again.
// Input beats are taken only between operations; the output register lets the
// next beat in while a result still waits.
module conditional_delay_command_table (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // delay_frames[15:0], command_tag[31:16],
	                              // required_conditions[35:32],
	                              // current_conditions[39:36]
	input  logic [2:0]  s_tuser,  // operation[2:0]
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // fired_tag[15:0]
	output logic        m_tuser,  // result_kind[0]
	output logic        m_tlast   // last result of this beat
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PASS = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	logic [1:0]                         state_q;
	logic [cdct_pkg::CNT_W-1:0]         count_q;
	logic [cdct_pkg::CNT_W-1:0]         ptr_q;
	logic [cdct_pkg::CNT_W-1:0]         ptr_m1;
	logic [cdct_pkg::IDX_W-1:0]         sel_idx;
	logic                               paused_q;
	logic [cdct_pkg::COND_W-1:0]        cur_q;

	logic                               accept;
	logic [cdct_pkg::OP_W-1:0]          op;
	logic                               full;
	logic                               add_ok;
	logic                               out_free;
	logic                               step;
	logic                               sel_fire;
	logic                               lower_fire;
	logic [cdct_pkg::TAG_W-1:0]         sel_tag;

	cdct_pkg::entry_t                   add_entry;
	cdct_pkg::entry_t                   cell_entry [cdct_pkg::TABLE_DEPTH];
	cdct_pkg::entry_t                   cell_above [cdct_pkg::TABLE_DEPTH];
	cdct_pkg::cell_ctrl_t               cell_ctrl [cdct_pkg::TABLE_DEPTH];
	logic [cdct_pkg::TABLE_DEPTH-1:0]   cell_fire;

	logic                               m_tvalid_q;
	logic                               m_tuser_q;
	logic                               m_tlast_q;
	logic [cdct_pkg::TAG_W-1:0]         m_tdata_q;

	// Input beat decode.
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign op = s_tuser;
	assign full = (count_q == cdct_pkg::CNT_W'(cdct_pkg::TABLE_DEPTH));
	assign add_ok = accept && (op == cdct_pkg::OP_ADD) && !full;

	assign add_entry.delay = s_tdata[15:0];
	assign add_entry.tag = s_tdata[31:16];
	assign add_entry.mask = s_tdata[35:32];

	// Selected cell of the walk and its neighbors below.
	assign ptr_m1 = ptr_q - 1'b1;
	assign sel_idx = ptr_m1[cdct_pkg::IDX_W-1:0];
	assign sel_fire = cell_fire[sel_idx];
	assign sel_tag = cell_entry[sel_idx].tag;

	always_comb begin
		lower_fire = 1'b0;
		for (int i = 0; i < cdct_pkg::TABLE_DEPTH; i++) begin
			if (i < int'(sel_idx)) begin
				lower_fire = lower_fire | cell_fire[i];
			end
		end
	end

	// The walk advances unless a firing entry finds the output occupied.
	assign out_free = !m_tvalid_q || m_tready;
	assign step = (state_q == ST_PASS) && (!sel_fire || out_free);

	// Per-cell control.
	always_comb begin
		for (int i = 0; i < cdct_pkg::TABLE_DEPTH; i++) begin
			cell_ctrl[i].wr = add_ok && (int'(count_q) == i);
			cell_ctrl[i].shift = step && sel_fire && (i >= int'(sel_idx));
			cell_ctrl[i].upd = step && !sel_fire && (i == int'(sel_idx));
		end
	end

	// Row of cells; each cell takes from the one above when a gap closes.
	generate
		for (genvar g = 0; g < cdct_pkg::TABLE_DEPTH; g++) begin : g_cell
			if (g == cdct_pkg::TABLE_DEPTH - 1) begin : g_top
				assign cell_above[g] = '0;
			end else begin : g_mid
				assign cell_above[g] = cell_entry[g+1];
			end

			cdct_cell u_cell (
				.clk       (clk),
				.ctrl      (cell_ctrl[g]),
				.cond      (cur_q),
				.add_entry (add_entry),
				.above     (cell_above[g]),
				.entry     (cell_entry[g]),
				.fire      (cell_fire[g])
			);
		end
	endgenerate

	// Sequencer, entry count and pause flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ptr_q <= '0;
			paused_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (op)
							cdct_pkg::OP_ADD: begin
								if (full) begin
									state_q <= ST_REJECT;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							cdct_pkg::OP_TICK: begin
								if (!paused_q && (count_q != '0)) begin
									ptr_q <= count_q;
									state_q <= ST_PASS;
								end
							end
							cdct_pkg::OP_CLEAR: begin
								count_q <= '0;
							end
							cdct_pkg::OP_PAUSE: begin
								paused_q <= 1'b1;
							end
							cdct_pkg::OP_RESUME: begin
								paused_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PASS: begin
					if (step) begin
						ptr_q <= ptr_m1;
						if (sel_fire) begin
							count_q <= count_q - 1'b1;
						end
						if (ptr_m1 == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_REJECT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Condition flags are held for the whole walk.
	always_ff @(posedge clk) begin
		if (accept && (op == cdct_pkg::OP_TICK)) begin
			cur_q <= s_tdata[39:36];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			priority if ((state_q == ST_REJECT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (step && sel_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if ((state_q == ST_REJECT) && out_free) begin
			m_tuser_q <= cdct_pkg::KIND_REJECT;
			m_tdata_q <= '0;
			m_tlast_q <= 1'b1;
		end else if (step && sel_fire) begin
			m_tuser_q <= cdct_pkg::KIND_FIRED;
			m_tdata_q <= sel_tag;
			m_tlast_q <= !lower_fire;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign m_tlast = m_tlast_q;

endmodule

// File: test/conditional_delay_command_table_tb.sv
// ----------------------------------------------------------------------------
// Conditional delay command table testbench
// Drives add, tick, clear, pause and resume commands into the table and
// checks every result beat against a table tracker kept in the bench. The run
// has directed cases first: a full table and its reject, a tick that fires
// every entry, pause and resume, clear, and the unused operation codes. Then
// come back-to-back traffic, a long output hold-off and random traffic, with
// random gaps on both streams.
// ----------------------------------------------------------------------------
module conditional_delay_command_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Operation codes the block ignores.
	localparam logic [cdct_pkg::OP_W-1:0] OP_NONE_LO = 3'd5;
	localparam logic [cdct_pkg::OP_W-1:0] OP_NONE_HI = 3'd7;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 2 * cdct_pkg::TABLE_DEPTH + 8;

	// One frame of aging on the tracked delay.
	localparam logic signed [cdct_pkg::DELAY_W:0] TRACK_STEP = (cdct_pkg::DELAY_W + 1)'(1);

	// Input beat payload, lowest field in the lowest bits.
	typedef struct packed {
		logic [cdct_pkg::COND_W-1:0]         cur;
		logic [cdct_pkg::COND_W-1:0]         req;
		logic [cdct_pkg::TAG_W-1:0]          tag;
		logic signed [cdct_pkg::DELAY_W-1:0] delay;
	} cmd_data_t;

	// One result beat as the table should produce it.
	typedef struct packed {
		logic                       kind;
		logic [cdct_pkg::TAG_W-1:0] tag;
		logic                       last;
	} table_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;  // delay_frames[15:0], command_tag[31:16],
	                            // required_conditions[35:32],
	                            // current_conditions[39:36]
	logic [2:0]  s_tuser = '0;  // operation[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;       // fired_tag[15:0]
	logic        m_tuser;       // result_kind[0]
	logic        m_tlast;

	// Tracked table contents.
	logic signed [cdct_pkg::DELAY_W:0] tbl_delay [cdct_pkg::TABLE_DEPTH];
	logic [cdct_pkg::COND_W-1:0]       tbl_mask [cdct_pkg::TABLE_DEPTH];
	logic [cdct_pkg::TAG_W-1:0]        tbl_tag [cdct_pkg::TABLE_DEPTH];
	logic [cdct_pkg::CNT_W-1:0]        tbl_count = '0;
	logic                              tbl_paused = 1'b0;

	table_result_t due_results[$];

	int errors = 0;
	int cycle_count = 0;
	int hold_left = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;

	conditional_delay_command_table u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Free-running clock, 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Cycle counter and run timeout.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		errors++;
	endtask

	// Queue one expected result at the end of the list.
	task automatic expect_result(input table_result_t r);
		due_results.insert(due_results.size(), r);
	endtask

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	// Mostly small delays around the firing point, sometimes any value.
	function automatic logic signed [cdct_pkg::DELAY_W-1:0] pick_delay();
		int v;
		if ($urandom_range(0, 9) < 7) begin
			v = $urandom_range(0, 5);
			return cdct_pkg::DELAY_W'(v - 1);
		end
		return cdct_pkg::DELAY_W'($urandom);
	endfunction

	// Update the tracked table for one accepted beat and queue its results.
	task automatic apply_table_op(input logic [cdct_pkg::OP_W-1:0] op, input cmd_data_t d);
		logic fire [cdct_pkg::TABLE_DEPTH];
		int lowest;
		int kept;
		table_result_t r;
		logic [cdct_pkg::IDX_W-1:0] slot;
		slot = tbl_count[cdct_pkg::IDX_W-1:0];
		case (op)
			cdct_pkg::OP_ADD: begin
				if (tbl_count >= cdct_pkg::TABLE_DEPTH) begin
					r.kind = cdct_pkg::KIND_REJECT;
					r.tag = '0;
					r.last = 1'b1;
					expect_result(r);
				end else begin
					tbl_delay[slot] = {d.delay[cdct_pkg::DELAY_W-1], d.delay};
					tbl_mask[slot] = d.req;
					tbl_tag[slot] = d.tag;
					tbl_count++;
				end
			end
			cdct_pkg::OP_TICK: begin
				if (!tbl_paused) begin
					// Age the active entries and find the ones now due.
					lowest = -1;
					for (int i = 0; i < tbl_count; i++) begin
						fire[i] = 1'b0;
						if ((tbl_mask[i] & d.cur) == tbl_mask[i]) begin
							tbl_delay[i] = tbl_delay[i] - TRACK_STEP;
							fire[i] = (tbl_delay[i] <= 0);
						end
						if (fire[i] && lowest < 0)
							lowest = i;
					end
					// Due entries come out from the highest index down.
					for (int k = int'(tbl_count) - 1; k >= 0; k--) begin
						if (fire[k]) begin
							r.kind = cdct_pkg::KIND_FIRED;
							r.tag = tbl_tag[k];
							r.last = (k == lowest);
							expect_result(r);
						end
					end
					// Close the gaps, keeping the order of what stays.
					kept = 0;
					for (int i = 0; i < tbl_count; i++) begin
						if (!fire[i]) begin
							tbl_delay[kept] = tbl_delay[i];
							tbl_mask[kept] = tbl_mask[i];
							tbl_tag[kept] = tbl_tag[i];
							kept++;
						end
					end
					tbl_count = cdct_pkg::CNT_W'(kept);
				end
			end
			cdct_pkg::OP_CLEAR: tbl_count = '0;
			cdct_pkg::OP_PAUSE: tbl_paused = 1'b1;
			cdct_pkg::OP_RESUME: tbl_paused = 1'b0;
			default: ;
		endcase
	endtask

	// Offer one beat after a random gap and hold it until it is taken.
	task automatic send_item(input logic [cdct_pkg::OP_W-1:0] op, input cmd_data_t d);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			s_tdata = {8'($urandom), $urandom};
			s_tuser = 3'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = d;
		do @(posedge clk); while (!s_tready);
		apply_table_op(op, d);
	endtask

	task automatic add_entry(input logic signed [cdct_pkg::DELAY_W-1:0] delay,
	                         input logic [cdct_pkg::TAG_W-1:0] tag,
	                         input logic [cdct_pkg::COND_W-1:0] req);
		cmd_data_t d;
		d = {4'($urandom), req, tag, delay};
		send_item(cdct_pkg::OP_ADD, d);
	endtask

	// Any operation other than add; the add fields carry noise.
	task automatic run_op(input logic [cdct_pkg::OP_W-1:0] op,
	                      input logic [cdct_pkg::COND_W-1:0] cur);
		cmd_data_t d;
		d = {cur, 4'($urandom), 16'($urandom), 16'($urandom)};
		send_item(op, d);
	endtask

	// Stop offering beats until every queued result has come out.
	task automatic wait_for_outcomes();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	// Fill the table with boundary values, then add once more to get a reject.
	task automatic test_fill_and_reject();
		add_entry(16'sh8000, 16'h0000, 4'h0);
		add_entry(16'sh0000, 16'hFFFF, 4'hF);
		for (int i = 2; i < cdct_pkg::TABLE_DEPTH; i++)
			add_entry(16'sh0001, 16'h0A00 + cdct_pkg::TAG_W'(i), cdct_pkg::COND_W'(i));
		add_entry(16'sh7FFF, 16'hFFFF, 4'hF);
		wait_for_outcomes();
	endtask

	// Every entry is active and due, so one tick empties the full table.
	task automatic test_fire_all();
		run_op(cdct_pkg::OP_TICK, 4'hF);
		wait_for_outcomes();
	endtask

	task automatic test_pause_resume();
		run_op(cdct_pkg::OP_PAUSE, 4'h0);
		add_entry(16'sh7FFF, 16'h7FFF, 4'h8);
		run_op(cdct_pkg::OP_TICK, 4'hF);
		run_op(cdct_pkg::OP_RESUME, 4'h0);
		// Required loading bit missing: nothing is due.
		run_op(cdct_pkg::OP_TICK, 4'h7);
		add_entry(16'sh0002, 16'h8000, 4'h5);
		run_op(cdct_pkg::OP_TICK, 4'h5);
		run_op(cdct_pkg::OP_TICK, 4'hD);
		wait_for_outcomes();
	endtask

	task automatic test_clear_and_spare_ops();
		run_op(OP_NONE_LO, 4'hF);
		run_op(OP_NONE_HI, 4'hF);
		run_op(cdct_pkg::OP_CLEAR, 4'h0);
		run_op(cdct_pkg::OP_TICK, 4'hF);
		wait_for_outcomes();
	endtask

	// Adds and ticks back to back with both streams always ready.
	task automatic test_back_to_back();
		idle_on = 1'b0;
		for (int i = 0; i < 20; i++) begin
			if (i % 3 == 2)
				run_op(cdct_pkg::OP_TICK, 4'hF);
			else
				add_entry(cdct_pkg::DELAY_W'($urandom_range(0, 2)), 16'($urandom),
				          4'($urandom));
		end
		wait_for_outcomes();
		idle_on = 1'b1;
	endtask

	// Hold the output off for a long stretch while ticks keep producing beats.
	task automatic test_output_holdoff();
		run_op(cdct_pkg::OP_RESUME, 4'h0);
		run_op(cdct_pkg::OP_CLEAR, 4'h0);
		hold_left = 150;
		for (int i = 0; i < 8; i++) begin
			add_entry(16'sh0001, 16'($urandom), 4'h0);
			add_entry(16'sh0001, 16'($urandom), 4'h0);
			run_op(cdct_pkg::OP_TICK, 4'($urandom));
		end
		wait_for_outcomes();
	endtask

	// Random commands, weighted toward adds and ticks that make the table fire.
	task automatic test_random_traffic(input int n_items);
		cmd_data_t d;
		int r;
		for (int i = 0; i < n_items; i++) begin
			d.delay = pick_delay();
			d.tag = 16'($urandom);
			d.req = ($urandom_range(0, 2) == 0) ? 4'h0 : 4'($urandom);
			d.cur = ($urandom_range(0, 1) == 0) ? 4'hF : 4'($urandom);
			r = $urandom_range(0, 99);
			if (r < 50)
				send_item(cdct_pkg::OP_ADD, d);
			else if (r < 90)
				send_item(cdct_pkg::OP_TICK, d);
			else if (r < 93)
				send_item(cdct_pkg::OP_CLEAR, d);
			else if (r < 95)
				send_item(cdct_pkg::OP_PAUSE, d);
			else if (r < 99)
				send_item(cdct_pkg::OP_RESUME, d);
			else
				send_item(cdct_pkg::OP_W'($urandom_range(OP_NONE_LO, OP_NONE_HI)), d);
			if ($urandom_range(0, 29) == 0)
				wait_for_outcomes();
		end
	endtask

	// Result side: long hold-off first, otherwise random stalls when enabled.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else if (!idle_on) begin
			m_tready = 1'b1;
		end else if (stall_left > 0) begin
			m_tready = 1'b0;
			stall_left--;
		end else begin
			stall_left = pick_gap();
			m_tready = (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Compare each result beat with the oldest queued result.
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("unexpected beat tag %0h kind %0b",
				                          m_tdata, m_tuser));
			end else begin
				want = due_results.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch($sformatf("kind %0b, want %0b", m_tuser, want.kind));
				if (m_tdata !== want.tag)
					report_mismatch($sformatf("tag %0h, want %0h", m_tdata, want.tag));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last));
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_fill_and_reject();
		test_fire_all();
		test_pause_resume();
		test_clear_and_spare_ops();
		test_back_to_back();
		test_output_holdoff();
		test_random_traffic(35);

		// Let any stray beat show up before the verdict.
		wait_for_outcomes();
		idle_on = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: conditional_delay_command_table.f
design/cdct_pkg.sv
design/cdct_cell.sv
design/conditional_delay_command_table.sv
test/conditional_delay_command_table_tb.sv
